[hdl/stdet_pkg.sv]
// ----------------------------------------------------------------------------
// stdet_pkg
// Shared types and constants of the sensor tamper detector: register indexes,
// register widths, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package stdet_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam int MAG_THR_W  = 17;
    localparam int PRESS_W    = 18;
    localparam int LIGHT_W    = 16;
    localparam int HITS_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_THRESHOLD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_THRESHOLD      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_LIMIT        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_HITS_NEEDED  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_BASELINE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_BASELINE       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_BASELINE  = 3'd7;

    localparam logic [MAG_THR_W-1:0]      RST_ACCEL_THRESHOLD    = 17'd1000;
    localparam logic [MAG_THR_W-1:0]      RST_MAG_THRESHOLD      = 17'd3000;
    localparam logic [PRESS_W-1:0]        RST_PRESSURE_THRESHOLD = 18'd1500;
    localparam logic signed [LIGHT_W-1:0] RST_LIGHT_LIMIT        = 16'sd1500;
    localparam logic [HITS_W-1:0]         RST_LIGHT_HITS_NEEDED  = 4'd3;

    typedef struct packed {
        logic [MAG_THR_W-1:0]      accel_threshold;
        logic [MAG_THR_W-1:0]      mag_threshold;
        logic [PRESS_W-1:0]        pressure_threshold;
        logic signed [LIGHT_W-1:0] light_limit;
        logic [HITS_W-1:0]         light_hits_needed;
        logic [MAG_THR_W-1:0]      accel_baseline;
        logic [MAG_THR_W-1:0]      mag_baseline;
        logic [PRESS_W-1:0]        pressure_baseline;
    } cfg_t;

endpackage

[hdl/stdet_cfg_regs.sv]
// ----------------------------------------------------------------------------
// stdet_cfg_regs
// Configuration register file: thresholds, baselines, the light limit and the light hit count.
// ----------------------------------------------------------------------------
module stdet_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [stdet_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stdet_pkg::CFG_DATA_W-1:0]    cfg_data,
    output stdet_pkg::cfg_t                     cfg
);

    stdet_pkg::cfg_t cfg_reg;
    stdet_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                stdet_pkg::REG_ACCEL_THRESHOLD:
                    cfg_next.accel_threshold = cfg_data[stdet_pkg::MAG_THR_W-1:0];
                stdet_pkg::REG_MAG_THRESHOLD:
                    cfg_next.mag_threshold = cfg_data[stdet_pkg::MAG_THR_W-1:0];
                stdet_pkg::REG_PRESSURE_THRESHOLD:
                    cfg_next.pressure_threshold = cfg_data[stdet_pkg::PRESS_W-1:0];
                stdet_pkg::REG_LIGHT_LIMIT:
                    cfg_next.light_limit = cfg_data[stdet_pkg::LIGHT_W-1:0];
                stdet_pkg::REG_LIGHT_HITS_NEEDED:
                    cfg_next.light_hits_needed = cfg_data[stdet_pkg::HITS_W-1:0];
                stdet_pkg::REG_ACCEL_BASELINE:
                    cfg_next.accel_baseline = cfg_data[stdet_pkg::MAG_THR_W-1:0];
                stdet_pkg::REG_MAG_BASELINE:
                    cfg_next.mag_baseline = cfg_data[stdet_pkg::MAG_THR_W-1:0];
                stdet_pkg::REG_PRESSURE_BASELINE:
                    cfg_next.pressure_baseline = cfg_data[stdet_pkg::PRESS_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_threshold    <= stdet_pkg::RST_ACCEL_THRESHOLD;
            cfg_reg.mag_threshold      <= stdet_pkg::RST_MAG_THRESHOLD;
            cfg_reg.pressure_threshold <= stdet_pkg::RST_PRESSURE_THRESHOLD;
            cfg_reg.light_limit        <= stdet_pkg::RST_LIGHT_LIMIT;
            cfg_reg.light_hits_needed  <= stdet_pkg::RST_LIGHT_HITS_NEEDED;
            cfg_reg.accel_baseline     <= '0;
            cfg_reg.mag_baseline       <= '0;
            cfg_reg.pressure_baseline  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/stdet_mag_check.sv]
// ----------------------------------------------------------------------------
// stdet_mag_check
// Three-axis Manhattan magnitude and its deviation check against a baseline.
// ----------------------------------------------------------------------------
module stdet_mag_check #(
    parameter int AXIS_BITS = 16
) (
    input  logic                                fresh,
    input  logic                                armed,
    input  logic signed [AXIS_BITS-1:0]         axis_x,
    input  logic signed [AXIS_BITS-1:0]         axis_y,
    input  logic signed [AXIS_BITS-1:0]         axis_z,
    input  logic [stdet_pkg::MAG_THR_W-1:0]     baseline,
    input  logic [stdet_pkg::MAG_THR_W-1:0]     threshold,
    output logic                                trip
);

    localparam int MAG_W = AXIS_BITS + 1;
    localparam int CMP_W = (MAG_W > stdet_pkg::MAG_THR_W) ? MAG_W : stdet_pkg::MAG_THR_W;

    logic [AXIS_BITS-1:0] abs_x;
    logic [AXIS_BITS-1:0] abs_y;
    logic [AXIS_BITS-1:0] abs_z;
    logic [MAG_W-1:0]     mag;
    logic [CMP_W-1:0]     mag_e;
    logic [CMP_W-1:0]     base_e;
    logic [CMP_W-1:0]     dev;

    assign abs_x = axis_x[AXIS_BITS-1] ? (~axis_x + 1'b1) : axis_x;
    assign abs_y = axis_y[AXIS_BITS-1] ? (~axis_y + 1'b1) : axis_y;
    assign abs_z = axis_z[AXIS_BITS-1] ? (~axis_z + 1'b1) : axis_z;

    assign mag    = MAG_W'(abs_x) + MAG_W'(abs_y) + MAG_W'(abs_z);
    assign mag_e  = CMP_W'(mag);
    assign base_e = CMP_W'(baseline);
    assign dev    = (mag_e >= base_e) ? (mag_e - base_e) : (base_e - mag_e);
    assign trip   = fresh & armed & (dev > CMP_W'(threshold));

endmodule

[hdl/stdet_light_count.sv]
// ----------------------------------------------------------------------------
// stdet_light_count
// Saturating count of bright light samples and the light trip decision.
// ----------------------------------------------------------------------------
module stdet_light_count (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    advance,
    input  logic                                    due,
    input  logic                                    armed,
    input  logic signed [stdet_pkg::LIGHT_W-1:0]    sample,
    input  logic signed [stdet_pkg::LIGHT_W-1:0]    threshold,
    input  logic [stdet_pkg::HITS_W-1:0]            hits_needed,
    output logic                                    trip
);

    logic [stdet_pkg::HITS_W-1:0] count_reg;
    logic [stdet_pkg::HITS_W-1:0] count_next;
    logic [stdet_pkg::HITS_W-1:0] count_step;
    logic                         bright;

    assign bright     = sample > threshold;
    assign count_step = (count_reg < hits_needed) ? (count_reg + 1'b1) : count_reg;

    always_comb
    begin
        trip       = 1'b0;
        count_next = count_reg;
        if (due)
        begin
            if (bright)
            begin
                if ((count_step >= hits_needed) && armed)
                begin
                    trip       = 1'b1;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_step;
                end
            end
            else
            begin
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (advance)
        begin
            count_reg <= count_next;
        end
    end

endmodule

[hdl/sensor_tamper_detector_unit.sv]
// ----------------------------------------------------------------------------
// sensor_tamper_detector_unit
// Safe tamper detector: motion, magnetic field, pressure and light trip flags
// from one sensor poll per request.
// ----------------------------------------------------------------------------
// One poll request is accepted per clock while in_ready is high and gives exactly one
// result of four trip flags, in order. A request lands in the input register, is evaluated
// in one pass of shallow logic (magnitudes, deviation compares, light hit count) and is
// written to the result register once that register is free or being read; out_valid
// then offers it. The result register lets a new request be taken while a finished
// result waits for out_ready. Configuration writes take effect on the next clock and
// are meant to be made while the block is idle.
module sensor_tamper_detector_unit #(
    parameter int AXIS_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [stdet_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [stdet_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [AXIS_BITS-1:0]             accel_x,
    input  logic signed [AXIS_BITS-1:0]             accel_y,
    input  logic signed [AXIS_BITS-1:0]             accel_z,
    input  logic                                    accel_fresh,
    input  logic signed [AXIS_BITS-1:0]             field_x,
    input  logic signed [AXIS_BITS-1:0]             field_y,
    input  logic signed [AXIS_BITS-1:0]             field_z,
    input  logic                                    field_fresh,
    input  logic [stdet_pkg::PRESS_W-1:0]           pressure,
    input  logic signed [stdet_pkg::LIGHT_W-1:0]    light_sample,
    input  logic                                    light_due,
    input  logic                                    armed,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic                                    motion_trip,
    output logic                                    field_trip,
    output logic                                    pressure_trip,
    output logic                                    light_trip
);

    stdet_pkg::cfg_t cfg;

    logic                                   in_valid_reg;
    logic signed [AXIS_BITS-1:0]            accel_x_reg;
    logic signed [AXIS_BITS-1:0]            accel_y_reg;
    logic signed [AXIS_BITS-1:0]            accel_z_reg;
    logic                                   accel_fresh_reg;
    logic signed [AXIS_BITS-1:0]            field_x_reg;
    logic signed [AXIS_BITS-1:0]            field_y_reg;
    logic signed [AXIS_BITS-1:0]            field_z_reg;
    logic                                   field_fresh_reg;
    logic [stdet_pkg::PRESS_W-1:0]          pressure_reg;
    logic signed [stdet_pkg::LIGHT_W-1:0]   light_sample_reg;
    logic                                   light_due_reg;
    logic                                   armed_reg;

    logic                                   out_valid_reg;
    logic                                   motion_trip_reg;
    logic                                   field_trip_reg;
    logic                                   pressure_trip_reg;
    logic                                   light_trip_reg;

    logic                                   advance;
    logic                                   accept;
    logic                                   motion_hit;
    logic                                   field_hit;
    logic                                   light_hit;
    logic                                   pressure_hit;
    logic [stdet_pkg::PRESS_W-1:0]          press_dev;

    assign advance  = in_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~in_valid_reg | advance;
    assign accept   = in_valid & in_ready;

    stdet_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    stdet_mag_check #(
        .AXIS_BITS (AXIS_BITS)
    ) u_accel_check (
        .fresh     (accel_fresh_reg),
        .armed     (armed_reg),
        .axis_x    (accel_x_reg),
        .axis_y    (accel_y_reg),
        .axis_z    (accel_z_reg),
        .baseline  (cfg.accel_baseline),
        .threshold (cfg.accel_threshold),
        .trip      (motion_hit)
    );

    stdet_mag_check #(
        .AXIS_BITS (AXIS_BITS)
    ) u_field_check (
        .fresh     (field_fresh_reg),
        .armed     (armed_reg),
        .axis_x    (field_x_reg),
        .axis_y    (field_y_reg),
        .axis_z    (field_z_reg),
        .baseline  (cfg.mag_baseline),
        .threshold (cfg.mag_threshold),
        .trip      (field_hit)
    );

    stdet_light_count u_light_count (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .due         (light_due_reg),
        .armed       (armed_reg),
        .sample      (light_sample_reg),
        .threshold   (cfg.light_limit),
        .hits_needed (cfg.light_hits_needed),
        .trip        (light_hit)
    );

    assign press_dev = (pressure_reg >= cfg.pressure_baseline)
                     ? (pressure_reg - cfg.pressure_baseline)
                     : (cfg.pressure_baseline - pressure_reg);
    assign pressure_hit = armed_reg & (press_dev > cfg.pressure_threshold);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            accel_x_reg      <= accel_x;
            accel_y_reg      <= accel_y;
            accel_z_reg      <= accel_z;
            accel_fresh_reg  <= accel_fresh;
            field_x_reg      <= field_x;
            field_y_reg      <= field_y;
            field_z_reg      <= field_z;
            field_fresh_reg  <= field_fresh;
            pressure_reg     <= pressure;
            light_sample_reg <= light_sample;
            light_due_reg    <= light_due;
            armed_reg        <= armed;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            motion_trip_reg   <= motion_hit;
            field_trip_reg    <= field_hit;
            pressure_trip_reg <= pressure_hit;
            light_trip_reg    <= light_hit;
        end
    end

    assign out_valid     = out_valid_reg;
    assign motion_trip   = motion_trip_reg;
    assign field_trip    = field_trip_reg;
    assign pressure_trip = pressure_trip_reg;
    assign light_trip    = light_trip_reg;

endmodule

[verif/tb_sensor_tamper_detector_unit.sv]
// ----------------------------------------------------------------------------
// tb_sensor_tamper_detector_unit
// Checks the tamper detector against a cycle-free model of its trip rules.
// Poll requests are sent with random gaps and the result side stalls at random.
// Every request is predicted at acceptance: Manhattan magnitudes against
// baseline and threshold, the pressure rule, and the light hit counter. Each
// result is compared flag by flag, in order. Directed polls cover the field
// extremes, the strict threshold edges, stale samples, disarmed bright light
// and the zero hit setting. Random polls follow, under several register
// settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_sensor_tamper_detector_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AXIS_W      = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_GAP     = 200;

    typedef struct {
        logic signed [AXIS_W-1:0]             accel_x;
        logic signed [AXIS_W-1:0]             accel_y;
        logic signed [AXIS_W-1:0]             accel_z;
        logic                                 accel_fresh;
        logic signed [AXIS_W-1:0]             field_x;
        logic signed [AXIS_W-1:0]             field_y;
        logic signed [AXIS_W-1:0]             field_z;
        logic                                 field_fresh;
        logic [stdet_pkg::PRESS_W-1:0]        pressure;
        logic signed [stdet_pkg::LIGHT_W-1:0] light_sample;
        logic                                 light_due;
        logic                                 armed;
    } poll_t;

    typedef struct {
        logic motion;
        logic field;
        logic pressure;
        logic light;
    } trips_t;

    logic                                 clk           = 1'b0;
    logic                                 rst_n         = 1'b0;
    logic                                 cfg_we        = 1'b0;
    logic [stdet_pkg::CFG_IDX_W-1:0]      cfg_index     = '0;
    logic [stdet_pkg::CFG_DATA_W-1:0]     cfg_data      = '0;
    logic                                 in_valid      = 1'b0;
    logic                                 in_ready;
    logic signed [AXIS_W-1:0]             accel_x       = '0;
    logic signed [AXIS_W-1:0]             accel_y       = '0;
    logic signed [AXIS_W-1:0]             accel_z       = '0;
    logic                                 accel_fresh   = 1'b0;
    logic signed [AXIS_W-1:0]             field_x       = '0;
    logic signed [AXIS_W-1:0]             field_y       = '0;
    logic signed [AXIS_W-1:0]             field_z       = '0;
    logic                                 field_fresh   = 1'b0;
    logic [stdet_pkg::PRESS_W-1:0]        pressure      = '0;
    logic signed [stdet_pkg::LIGHT_W-1:0] light_sample  = '0;
    logic                                 light_due     = 1'b0;
    logic                                 armed         = 1'b0;
    logic                                 out_valid;
    logic                                 out_ready     = 1'b0;
    logic                                 motion_trip;
    logic                                 field_trip;
    logic                                 pressure_trip;
    logic                                 light_trip;

    stdet_pkg::cfg_t model_cfg;
    logic [3:0]   bright_hits;
    trips_t       expected_trips[$];
    int           mismatches    = 0;
    int           cycle_count   = 0;
    int           send_idle_pct = 0;
    int           ready_stall_pct = 0;
    int           hold_len      = 0;
    int           hold_ticket   = 0;
    int           hold_served   = 0;
    int           hold_left     = 0;

    sensor_tamper_detector_unit #(
        .AXIS_BITS(AXIS_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .accel_fresh  (accel_fresh),
        .field_x      (field_x),
        .field_y      (field_y),
        .field_z      (field_z),
        .field_fresh  (field_fresh),
        .pressure     (pressure),
        .light_sample (light_sample),
        .light_due    (light_due),
        .armed        (armed),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .motion_trip  (motion_trip),
        .field_trip   (field_trip),
        .pressure_trip(pressure_trip),
        .light_trip   (light_trip)
    );

    always
    begin
        #1;
        clk = 1'b1;
        #1;
        clk = 1'b0;
    end

    function automatic int abs_val(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int axis_sum(logic signed [AXIS_W-1:0] x, logic signed [AXIS_W-1:0] y,
                                    logic signed [AXIS_W-1:0] z);
        int vx;
        int vy;
        int vz;
        vx = int'(x);
        vy = int'(y);
        vz = int'(z);
        return abs_val(vx) + abs_val(vy) + abs_val(vz);
    endfunction

    function automatic trips_t predict_trips(poll_t p);
        trips_t t;
        int     light_level;
        int     light_limit;
        t.motion   = p.accel_fresh && p.armed &&
                     abs_val(axis_sum(p.accel_x, p.accel_y, p.accel_z) -
                             int'(model_cfg.accel_baseline)) > int'(model_cfg.accel_threshold);
        t.field    = p.field_fresh && p.armed &&
                     abs_val(axis_sum(p.field_x, p.field_y, p.field_z) -
                             int'(model_cfg.mag_baseline)) > int'(model_cfg.mag_threshold);
        t.pressure = p.armed &&
                     abs_val(int'(p.pressure) - int'(model_cfg.pressure_baseline)) >
                     int'(model_cfg.pressure_threshold);
        t.light    = 1'b0;
        light_level = int'(p.light_sample);
        light_limit = int'(model_cfg.light_limit);
        if (p.light_due)
        begin
            if (light_level > light_limit)
            begin
                if (bright_hits < model_cfg.light_hits_needed)
                    bright_hits = bright_hits + 4'd1;
                if (bright_hits >= model_cfg.light_hits_needed && p.armed)
                begin
                    t.light     = 1'b1;
                    bright_hits = '0;
                end
            end
            else
                bright_hits = '0;
        end
        return t;
    endfunction

    function automatic void set_model_reg(logic [stdet_pkg::CFG_IDX_W-1:0] idx,
                                          logic [stdet_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            stdet_pkg::REG_ACCEL_THRESHOLD:
                model_cfg.accel_threshold    = data[stdet_pkg::MAG_THR_W-1:0];
            stdet_pkg::REG_MAG_THRESHOLD:
                model_cfg.mag_threshold      = data[stdet_pkg::MAG_THR_W-1:0];
            stdet_pkg::REG_PRESSURE_THRESHOLD:
                model_cfg.pressure_threshold = data[stdet_pkg::PRESS_W-1:0];
            stdet_pkg::REG_LIGHT_LIMIT:
                model_cfg.light_limit        = data[stdet_pkg::LIGHT_W-1:0];
            stdet_pkg::REG_LIGHT_HITS_NEEDED:
                model_cfg.light_hits_needed  = data[stdet_pkg::HITS_W-1:0];
            stdet_pkg::REG_ACCEL_BASELINE:
                model_cfg.accel_baseline     = data[stdet_pkg::MAG_THR_W-1:0];
            stdet_pkg::REG_MAG_BASELINE:
                model_cfg.mag_baseline       = data[stdet_pkg::MAG_THR_W-1:0];
            stdet_pkg::REG_PRESSURE_BASELINE:
                model_cfg.pressure_baseline  = data[stdet_pkg::PRESS_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int near_value(int base, int thr, int ceiling);
        int v;
        v = base + int'($urandom_range(0, 2 * thr + 2)) - thr - 1;
        if (v < 0)
            v = 0;
        if (v > ceiling)
            v = ceiling;
        return v;
    endfunction

    function automatic logic signed [AXIS_W-1:0] signed_axis(int m);
        int v;
        v = (m == 32768 || $urandom_range(0, 1) == 1) ? -m : m;
        return v[AXIS_W-1:0];
    endfunction

    function automatic void near_axes(input int total, output logic signed [AXIS_W-1:0] x,
                                      output logic signed [AXIS_W-1:0] y,
                                      output logic signed [AXIS_W-1:0] z);
        int a;
        int r;
        int b;
        a = $urandom_range((total > 65536) ? total - 65536 : 0, (total < 32768) ? total : 32768);
        r = total - a;
        b = $urandom_range((r > 32768) ? r - 32768 : 0, (r < 32768) ? r : 32768);
        x = signed_axis(a);
        y = signed_axis(b);
        z = signed_axis(r - b);
    endfunction

    function automatic poll_t rand_poll();
        poll_t p;
        int    level;
        int    limit;
        int    press;
        if ($urandom_range(0, 1) == 1)
        begin
            p.accel_x = AXIS_W'($urandom);
            p.accel_y = AXIS_W'($urandom);
            p.accel_z = AXIS_W'($urandom);
        end
        else
            near_axes(near_value(int'(model_cfg.accel_baseline),
                                 int'(model_cfg.accel_threshold), 98304),
                      p.accel_x, p.accel_y, p.accel_z);
        if ($urandom_range(0, 1) == 1)
        begin
            p.field_x = AXIS_W'($urandom);
            p.field_y = AXIS_W'($urandom);
            p.field_z = AXIS_W'($urandom);
        end
        else
            near_axes(near_value(int'(model_cfg.mag_baseline),
                                 int'(model_cfg.mag_threshold), 98304),
                      p.field_x, p.field_y, p.field_z);
        if ($urandom_range(0, 1) == 1)
            press = $urandom;
        else
            press = near_value(int'(model_cfg.pressure_baseline),
                               int'(model_cfg.pressure_threshold), 262143);
        p.pressure = press[stdet_pkg::PRESS_W-1:0];
        limit = int'(model_cfg.light_limit);
        if ($urandom_range(0, 3) == 0)
            level = $signed(16'($urandom));
        else if ($urandom_range(0, 9) != 0)
            level = limit + int'($urandom_range(1, 3));
        else
            level = limit - int'($urandom_range(0, 3));
        if (level > 32767)
            level = 32767;
        if (level < -32768)
            level = -32768;
        p.light_sample = level[stdet_pkg::LIGHT_W-1:0];
        p.accel_fresh  = $urandom_range(0, 3) != 0;
        p.field_fresh  = $urandom_range(0, 3) != 0;
        p.light_due    = $urandom_range(0, 4) < 3;
        p.armed        = $urandom_range(0, 3) != 0;
        return p;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_poll(input poll_t p);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        accel_x      <= p.accel_x;
        accel_y      <= p.accel_y;
        accel_z      <= p.accel_z;
        accel_fresh  <= p.accel_fresh;
        field_x      <= p.field_x;
        field_y      <= p.field_y;
        field_z      <= p.field_z;
        field_fresh  <= p.field_fresh;
        pressure     <= p.pressure;
        light_sample <= p.light_sample;
        light_due    <= p.light_due;
        armed        <= p.armed;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_trips.push_back(predict_trips(p));
        @(negedge clk);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        while (expected_trips.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [stdet_pkg::CFG_IDX_W-1:0] idx,
                             input logic [stdet_pkg::CFG_DATA_W-1:0] data);
        set_model_reg(idx, data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_random(input int n);
        repeat (n) send_poll(rand_poll());
        wait_results();
    endtask

    task automatic flag_mismatch(input string name, input logic exp_bit, input logic act_bit);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s mismatch: expected %b actual %b", $realtime, name, exp_bit, act_bit);
    endtask

    always @(posedge clk)
    begin
        trips_t exp_t;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_trips.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t result with no request pending", $realtime);
            end
            else
            begin
                exp_t = expected_trips.pop_front();
                if (exp_t.motion !== motion_trip)
                    flag_mismatch("motion_trip", exp_t.motion, motion_trip);
                if (exp_t.field !== field_trip)
                    flag_mismatch("field_trip", exp_t.field, field_trip);
                if (exp_t.pressure !== pressure_trip)
                    flag_mismatch("pressure_trip", exp_t.pressure, pressure_trip);
                if (exp_t.light !== light_trip)
                    flag_mismatch("light_trip", exp_t.light, light_trip);
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_ticket != hold_served)
        begin
            hold_served = hold_ticket;
            hold_left   = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_directed_defaults();
        // stale samples, then axis and pressure extremes
        send_poll('{-32768, -32768, -32768, 0, -32768, -32768, -32768, 0, 0, 0, 0, 1});
        send_poll('{-32768, -32768, -32768, 1, -32768, -32768, -32768, 1, 262143, 32767, 0, 1});
        send_poll('{32767, 32767, 32767, 1, 32767, 32767, 32767, 1, 1500, -32768, 1, 1});
        // strict threshold edges
        send_poll('{1000, 0, 0, 1, 0, 3000, 0, 1, 1501, 0, 0, 1});
        send_poll('{0, -1001, 0, 1, 0, 0, -3001, 1, 1499, 0, 0, 1});
        send_poll('{500, -250, 251, 1, 1000, -1000, 1001, 1, 262143, 0, 0, 0});
        // bright while disarmed saturates, first armed bright trips
        repeat (4) send_poll('{0, 0, 0, 1, 0, 0, 0, 1, 0, 1501, 1, 0});
        send_poll('{0, 0, 0, 1, 0, 0, 0, 1, 0, 32767, 1, 1});
        send_poll('{0, 0, 0, 1, 0, 0, 0, 1, 0, 1500, 1, 1});
        send_poll('{0, 0, 0, 1, 0, 0, 0, 1, 0, 1501, 1, 1});
        send_poll('{0, 0, 0, 1, 0, 0, 0, 1, 0, 1501, 1, 1});
        // not due keeps the count
        send_poll('{0, 0, 0, 1, 0, 0, 0, 1, 0, 32767, 0, 1});
        send_poll('{0, 0, 0, 1, 0, 0, 0, 1, 0, 2000, 1, 1});
        send_poll('{0, 0, 0, 1, 0, 0, 0, 1, 0, 2000, 1, 1});
        send_poll('{0, 0, 0, 1, 0, 0, 0, 1, 0, -5, 1, 1});
        repeat (3) send_poll('{0, 0, 0, 1, 0, 0, 0, 1, 0, 1600, 1, 1});
        wait_results();
    endtask

    task automatic test_register_extremes();
        write_reg(stdet_pkg::REG_ACCEL_THRESHOLD, 18'd0);
        write_reg(stdet_pkg::REG_MAG_THRESHOLD, 18'd0);
        write_reg(stdet_pkg::REG_PRESSURE_THRESHOLD, 18'd0);
        write_reg(stdet_pkg::REG_LIGHT_LIMIT, 18'(-32768));
        write_reg(stdet_pkg::REG_LIGHT_HITS_NEEDED, 18'd1);
        write_reg(stdet_pkg::REG_ACCEL_BASELINE, 18'd0);
        write_reg(stdet_pkg::REG_MAG_BASELINE, 18'd0);
        write_reg(stdet_pkg::REG_PRESSURE_BASELINE, 18'd0);
        send_poll('{0, 0, 0, 1, 0, 0, 0, 1, 0, -32768, 1, 1});
        send_poll('{1, 0, 0, 1, 0, 0, -1, 1, 1, -32767, 1, 1});
        run_random(40);
        // all ones, wider than the narrow registers
        write_reg(stdet_pkg::REG_ACCEL_THRESHOLD, 18'h3FFFF);
        write_reg(stdet_pkg::REG_MAG_THRESHOLD, 18'h3FFFF);
        write_reg(stdet_pkg::REG_PRESSURE_THRESHOLD, 18'h3FFFF);
        write_reg(stdet_pkg::REG_LIGHT_LIMIT, 18'h3FFFF);
        write_reg(stdet_pkg::REG_LIGHT_HITS_NEEDED, 18'h3FFFF);
        write_reg(stdet_pkg::REG_ACCEL_BASELINE, 18'h3FFFF);
        write_reg(stdet_pkg::REG_MAG_BASELINE, 18'h3FFFF);
        write_reg(stdet_pkg::REG_PRESSURE_BASELINE, 18'h3FFFF);
        send_poll('{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 1, 1});
        repeat (16) send_poll('{-32768, -32768, -32768, 1, 32767, 32767, 32767, 1, 0, 32767, 1, 1});
        run_random(60);
    endtask

    task automatic test_zero_hits();
        write_reg(stdet_pkg::REG_ACCEL_THRESHOLD, 18'd98304);
        write_reg(stdet_pkg::REG_MAG_THRESHOLD, 18'd98304);
        write_reg(stdet_pkg::REG_PRESSURE_THRESHOLD, 18'd262143);
        write_reg(stdet_pkg::REG_LIGHT_LIMIT, 18'd0);
        write_reg(stdet_pkg::REG_LIGHT_HITS_NEEDED, 18'd0);
        write_reg(stdet_pkg::REG_ACCEL_BASELINE, 18'd98304);
        write_reg(stdet_pkg::REG_MAG_BASELINE, 18'd98304);
        write_reg(stdet_pkg::REG_PRESSURE_BASELINE, 18'd262143);
        send_poll('{0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 1, 1});
        send_poll('{0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 1, 0});
        send_poll('{0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 1, 1});
        send_poll('{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 1, 1});
        run_random(60);
    endtask

    task automatic rand_config();
        write_reg(stdet_pkg::REG_ACCEL_THRESHOLD, 18'($urandom_range(0, 6000)));
        write_reg(stdet_pkg::REG_MAG_THRESHOLD, 18'($urandom_range(0, 8000)));
        write_reg(stdet_pkg::REG_PRESSURE_THRESHOLD, 18'($urandom_range(0, 5000)));
        write_reg(stdet_pkg::REG_LIGHT_LIMIT, 18'(int'($urandom_range(0, 8000)) - 4000));
        write_reg(stdet_pkg::REG_LIGHT_HITS_NEEDED, 18'($urandom_range(1, 6)));
        write_reg(stdet_pkg::REG_ACCEL_BASELINE, 18'($urandom_range(0, 98304)));
        write_reg(stdet_pkg::REG_MAG_BASELINE, 18'($urandom_range(0, 98304)));
        write_reg(stdet_pkg::REG_PRESSURE_BASELINE, 18'($urandom_range(0, 262143)));
    endtask

    task automatic test_random_traffic(input int send_pct, input int stall_pct, input int n);
        send_idle_pct   = send_pct;
        ready_stall_pct = stall_pct;
        rand_config();
        run_random(n);
        send_idle_pct   = 0;
        ready_stall_pct = 0;
    endtask

    task automatic test_output_hold_off();
        rand_config();
        @(posedge clk);
        hold_len = 60;
        hold_ticket++;
        @(negedge clk);
        repeat (24) send_poll(rand_poll());
        wait_results();
        run_random(10);
    endtask

    initial
    begin
        model_cfg = '{stdet_pkg::RST_ACCEL_THRESHOLD, stdet_pkg::RST_MAG_THRESHOLD,
                      stdet_pkg::RST_PRESSURE_THRESHOLD, stdet_pkg::RST_LIGHT_LIMIT,
                      stdet_pkg::RST_LIGHT_HITS_NEEDED, '0, '0, '0};
        bright_hits = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_defaults();
        test_register_extremes();
        test_zero_hits();
        test_random_traffic(0, 0, 215);
        test_random_traffic(84, 0, 215);
        test_random_traffic(0, 84, 215);
        test_random_traffic(17, 17, 215);
        test_output_hold_off();
        wait_results();
        if (mismatches == 0 && expected_trips.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
